@@ design/dtn_pkg.sv @@
`timescale 1ns / 1ps
// Package for the distributed depth-first traversal token node.
// Holds widths, codes, the shared request/response structs and the bit helpers.
// No dependencies; every other design file imports it.
package dtn_pkg;

    localparam int NODES     = 16;
    localparam int MASK_W    = 16;
    localparam int NODE_W    = 4;
    localparam int LFSR_W    = 16;
    localparam int CNT_W     = $clog2(MASK_W + 1);
    localparam int STEP_W    = $clog2(LFSR_W);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int FUNC_W    = 2;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // Only neighbors numbered below NODES take part.
    localparam logic [MASK_W-1:0] NODE_LIMIT =
        (NODES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << NODES) - 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEIGHBOR_MASK = 2'd0,
        CFG_IS_ROOT       = 2'd1,
        CFG_LFSR_SEED     = 2'd2
    } cfg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START   = 2'd0,
        FUNC_FORWARD = 2'd1,
        FUNC_RETURN  = 2'd2
    } func_t;

    typedef enum logic {
        MSG_FORWARD = 1'b0,
        MSG_RETURN  = 1'b1
    } msg_kind_t;

    typedef struct packed {
        logic              start;
        logic [LFSR_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [NODE_W-1:0] remainder;
    } mod_rsp_t;

    function automatic logic [CNT_W-1:0] popcount(input logic [MASK_W-1:0] m);
        logic [CNT_W-1:0] cnt;
        cnt = '0;
        for (int i = 0; i < MASK_W; i++) begin
            cnt = cnt + CNT_W'(m[i]);
        end
        return cnt;
    endfunction

    // Position of the k-th set bit, counting from bit 0. Each bit compares the
    // count of set bits below it with k, so at most one bit hits.
    function automatic logic [NODE_W-1:0] select_kth(input logic [MASK_W-1:0] m,
                                                     input logic [NODE_W-1:0] k);
        logic [NODE_W-1:0] sel;
        logic [MASK_W-1:0] below;
        sel = '0;
        for (int i = 0; i < MASK_W; i++) begin
            below = m & ((MASK_W'(1) << i) - MASK_W'(1));
            if (m[i] && (popcount(below) == {1'b0, k})) begin
                sel = NODE_W'(i);
            end
        end
        return sel;
    endfunction

endpackage

@@ design/dtn_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the token node: incoming events and results.
// Depends on dtn_pkg for field widths.
interface dtn_evt_if
    import dtn_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] source_node;

    modport source (output valid, output func, output source_node, input ready);
    modport sink   (input valid, input func, input source_node, output ready);
endinterface

interface dtn_res_if
    import dtn_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              send_valid;
    logic [NODE_W-1:0] dest_node;
    logic              msg_kind;
    logic              finished;
    logic              traversal_done;

    modport source (output valid, output send_valid, output dest_node, output msg_kind,
                    output finished, output traversal_done, input ready);
    modport sink   (input valid, input send_valid, input dest_node, input msg_kind,
                    input finished, input traversal_done, output ready);
endinterface

@@ design/distributed_dfs_token_node.sv @@
`timescale 1ns / 1ps
// Top level of the distributed depth-first traversal token node.
// Depends on dtn_pkg, dtn_if.sv (channel interfaces) and dtn_mod_unit.
//
//  Channel  Dir  Content
//  evt      in   func, source_node (one event per transfer)
//  result   out  send_valid, dest_node, msg_kind, finished, traversal_done
//  cfg_*    in   write enable, register index, write data (no handshake)
//
// An event with no neighbor pick goes from idle through the write state to the output register.
// A pick adds the pick state, where the modulo unit steps through the LFSR bits one by one.
// One event is in work at a time; evt.ready is high only while the sequencer idles.
// A stalled result is held in the output register; the next event is taken meanwhile.
// Reset loads an empty neighbor mask, a cleared node state and an LFSR of 1.
module distributed_dfs_token_node
    import dtn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    dtn_evt_if.sink              evt,
    dtn_res_if.source            result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_WRITE
    } state_t;

    state_t            state_reg, state_next;
    logic [MASK_W-1:0] remaining_reg, remaining_next;
    logic              participated_reg, participated_next;
    logic [NODE_W-1:0] father_reg, father_next;
    logic              has_father_reg, has_father_next;
    logic              done_reg, done_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic              is_root_reg, is_root_next;

    logic              res_send_reg, res_send_next;
    logic [NODE_W-1:0] res_dest_reg, res_dest_next;
    logic              res_kind_reg, res_kind_next;
    logic              res_tdone_reg, res_tdone_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_send_reg, out_send_next;
    logic [NODE_W-1:0] out_dest_reg, out_dest_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_finished_reg, out_finished_next;
    logic              out_tdone_reg, out_tdone_next;

    logic              accept;
    logic              pick;
    logic [LFSR_W-1:0] lfsr_step;
    logic [MASK_W-1:0] rm_removed;
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;

    dtn_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign evt.ready  = (state_reg == ST_IDLE);
    assign accept     = evt.valid && evt.ready;
    assign lfsr_step  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign rm_removed = remaining_reg & ~(MASK_W'(1) << evt.source_node);

    always_comb
    begin
        state_next        = state_reg;
        remaining_next    = remaining_reg;
        participated_next = participated_reg;
        father_next       = father_reg;
        has_father_next   = has_father_reg;
        done_next         = done_reg;
        lfsr_next         = lfsr_reg;
        is_root_next      = is_root_reg;
        res_send_next     = res_send_reg;
        res_dest_next     = res_dest_reg;
        res_kind_next     = res_kind_reg;
        res_tdone_next    = res_tdone_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_send_next     = out_send_reg;
        out_dest_next     = out_dest_reg;
        out_kind_next     = out_kind_reg;
        out_finished_next = out_finished_reg;
        out_tdone_next    = out_tdone_reg;
        pick              = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                CFG_NEIGHBOR_MASK: remaining_next = cfg_data & NODE_LIMIT;
                CFG_IS_ROOT:       is_root_next   = cfg_data[0];
                CFG_LFSR_SEED:     lfsr_next      = (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    res_send_next  = 1'b0;
                    res_dest_next  = '0;
                    res_kind_next  = MSG_FORWARD;
                    res_tdone_next = 1'b0;
                    if (!done_reg) begin
                        case (evt.func)
                            FUNC_START:
                            begin
                                if (is_root_reg && !participated_reg) begin
                                    participated_next = 1'b1;
                                    if (remaining_reg != '0) begin
                                        pick = 1'b1;
                                    end else begin
                                        done_next      = 1'b1;
                                        res_tdone_next = 1'b1;
                                    end
                                end
                            end
                            FUNC_FORWARD:
                            begin
                                remaining_next = rm_removed;
                                if (!participated_reg && rm_removed != '0) begin
                                    father_next       = evt.source_node;
                                    has_father_next   = 1'b1;
                                    participated_next = 1'b1;
                                    pick              = 1'b1;
                                end else begin
                                    res_send_next = 1'b1;
                                    res_dest_next = evt.source_node;
                                    res_kind_next = MSG_RETURN;
                                    if (!participated_reg) begin
                                        done_next = 1'b1;
                                    end
                                end
                            end
                            FUNC_RETURN:
                            begin
                                remaining_next = rm_removed;
                                if (rm_removed == '0) begin
                                    if (has_father_reg) begin
                                        res_send_next = 1'b1;
                                        res_dest_next = father_reg;
                                        res_kind_next = MSG_RETURN;
                                    end else begin
                                        res_tdone_next = 1'b1;
                                    end
                                    participated_next = 1'b0;
                                    done_next         = 1'b1;
                                end else begin
                                    pick = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (pick) begin
                        lfsr_next     = lfsr_step;
                        res_send_next = 1'b1;
                        res_kind_next = MSG_FORWARD;
                        state_next    = ST_PICK;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_PICK:
            begin
                if (mod_rsp.done) begin
                    res_dest_next = select_kth(remaining_reg, mod_rsp.remainder);
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || result.ready) begin
                    out_valid_next    = 1'b1;
                    out_send_next     = res_send_reg;
                    out_dest_next     = res_dest_reg;
                    out_kind_next     = res_kind_reg;
                    out_finished_next = done_reg;
                    out_tdone_next    = res_tdone_reg;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // The pick mask is the one left after removing the source, if the event removes one.
        mod_req.start    = pick;
        mod_req.dividend = lfsr_step;
        mod_req.divisor  = popcount(remaining_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            remaining_reg    <= '0;
            participated_reg <= 1'b0;
            father_reg       <= '0;
            has_father_reg   <= 1'b0;
            done_reg         <= 1'b0;
            lfsr_reg         <= LFSR_W'(1);
            is_root_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            remaining_reg    <= remaining_next;
            participated_reg <= participated_next;
            father_reg       <= father_next;
            has_father_reg   <= has_father_next;
            done_reg         <= done_next;
            lfsr_reg         <= lfsr_next;
            is_root_reg      <= is_root_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_send_reg     <= res_send_next;
        res_dest_reg     <= res_dest_next;
        res_kind_reg     <= res_kind_next;
        res_tdone_reg    <= res_tdone_next;
        out_send_reg     <= out_send_next;
        out_dest_reg     <= out_dest_next;
        out_kind_reg     <= out_kind_next;
        out_finished_reg <= out_finished_next;
        out_tdone_reg    <= out_tdone_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.send_valid     = out_send_reg;
    assign result.dest_node      = out_dest_reg;
    assign result.msg_kind       = out_kind_reg;
    assign result.finished       = out_finished_reg;
    assign result.traversal_done = out_tdone_reg;

`ifndef NO_ASSERTIONS
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("finished flag cleared after finishing");

    a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PICK |-> remaining_reg != '0)
        else $error("neighbor pick on an empty mask");

    a_tdone_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.traversal_done |-> result.finished && !result.send_valid)
        else $error("traversal done without finishing or with a send");

    a_mod_done_in_pick: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> state_reg == ST_PICK)
        else $error("modulo result outside the pick state");
`endif

endmodule

@@ design/dtn_mod_unit.sv @@
`timescale 1ns / 1ps
// Iterative restoring modulo unit: one dividend bit per cycle.
// Depends on dtn_pkg for the request and response structs.
module dtn_mod_unit
    import dtn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(LFSR_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [LFSR_W-1:0] dividend_reg, dividend_next;
    logic [CNT_W-1:0]  divisor_reg, divisor_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  trial;

    // The remainder stays below the divisor, so its top bit is always clear.
    assign trial = {rem_reg[CNT_W-2:0], dividend_reg[LFSR_W-1]};

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        step_next     = step_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        if (req.start) begin
            busy_next     = 1'b1;
            step_next     = '0;
            dividend_next = req.dividend;
            divisor_next  = req.divisor;
            rem_next      = '0;
        end else if (busy_reg) begin
            rem_next      = (trial >= divisor_reg) ? trial - divisor_reg : trial;
            dividend_next = {dividend_reg[LFSR_W-2:0], 1'b0};
            step_next     = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[NODE_W-1:0];

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("modulo start while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start && step_reg == LAST_STEP |=> rsp.done && !busy_reg)
        else $error("modulo did not finish after its last step");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> rem_reg < divisor_reg)
        else $error("modulo remainder not below divisor");
`endif

endmodule
